@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Implication form of the above, the consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/nfa_ssm_pkg.sv @@
// Package with the shared types and codes of the automaton matcher.
`default_nettype none
package nfa_ssm_pkg;

	// Fixed field widths of the external interface.
	localparam int REQ_W   = 2;
	localparam int STATE_W = 5;
	localparam int SYM_W   = 8;
	localparam int MASK_W  = 32;
	localparam int CFG_IDX_W = 1;

	// Request codes; the fourth code is unused and ignored.
	typedef enum logic [REQ_W-1:0] {
		REQ_WRITE  = 2'd0,
		REQ_SYMBOL = 2'd1,
		REQ_END    = 2'd2
	} req_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_START_STATE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_MASK = 1'b1;

	// Controller states.
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_APPLY,
		ST_REPORT
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_en;
		logic capture;
		logic tbl_wr;
		logic step;
		logic report;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic             clear_done;
		logic [REQ_W-1:0] req_type;
		logic             is_last;
	} dp_status_t;

endpackage
`default_nettype wire

@@ sv/nfa_ssm_ctrl.sv @@
// Controller state machine of the automaton matcher.
`default_nettype none
module nfa_ssm_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [nfa_ssm_pkg::REQ_W-1:0] req_type,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output nfa_ssm_pkg::ctrl_cmd_t         cmd,
	input  wire nfa_ssm_pkg::dp_status_t   status
);
	import nfa_ssm_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;
	logic        accept;
	logic        slot_free;

	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (status.clear_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (req_type) inside
						REQ_WRITE, REQ_SYMBOL: state_d = ST_APPLY;
						REQ_END:               state_d = ST_REPORT;
						default:               state_d = ST_IDLE;
					endcase
				end
			end
			ST_APPLY: begin
				if (status.req_type == REQ_SYMBOL && status.is_last) begin
					state_d = ST_REPORT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_REPORT: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// Output decode.
	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		cmd.clear_en = (state_q == ST_CLEAR);
		cmd.capture  = accept;
		cmd.tbl_wr   = (state_q == ST_APPLY) && (status.req_type == REQ_WRITE);
		cmd.step     = (state_q == ST_APPLY) && (status.req_type == REQ_SYMBOL);
		cmd.report   = (state_q == ST_REPORT) && slot_free;
	end

	// State register and the output beat flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.report) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/nfa_ssm_dp.sv @@
// Datapath of the automaton matcher: banked transition table, active set and result.
`default_nettype none
module nfa_ssm_dp #(
	parameter int NUM_STATES  = 32,
	parameter int SYMBOL_BITS = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire nfa_ssm_pkg::ctrl_cmd_t            cmd,
	output nfa_ssm_pkg::dp_status_t                status,
	input  wire logic                              cfg_wr_en,
	input  wire logic [nfa_ssm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [nfa_ssm_pkg::MASK_W-1:0]    cfg_wdata,
	input  wire logic [nfa_ssm_pkg::REQ_W-1:0]     req_type,
	input  wire logic [nfa_ssm_pkg::STATE_W-1:0]   from_state,
	input  wire logic [nfa_ssm_pkg::SYM_W-1:0]     symbol,
	input  wire logic [nfa_ssm_pkg::MASK_W-1:0]    next_mask,
	input  wire logic                              is_last,
	output logic                                   matched,
	output logic                                   died
);
	import nfa_ssm_pkg::*;

	// Stored entry width: only the low target bits can ever be set.
	localparam int TW    = (NUM_STATES < MASK_W) ? NUM_STATES : MASK_W;
	localparam int DEPTH = 1 << SYMBOL_BITS;

	// Captured item.
	logic [REQ_W-1:0]       req_q;
	logic [STATE_W-1:0]     from_q;
	logic [SYMBOL_BITS-1:0] sym_q;
	logic                   sym_ok_q;
	logic [TW-1:0]          mask_q;
	logic                   last_q;

	// Configuration, active set and clearing counter.
	logic [STATE_W-1:0]     start_q;
	logic [MASK_W-1:0]      accept_q;
	logic [NUM_STATES-1:0]  active_q;
	logic                   fresh_q;
	logic [SYMBOL_BITS-1:0] clr_cnt_q;
	logic                   matched_q;
	logic                   died_q;

	// Bank read data, one word per source state.
	logic [TW-1:0]          rd_q [NUM_STATES];

	logic [NUM_STATES-1:0]  start_set;
	logic [NUM_STATES-1:0]  accept_ns;
	logic [NUM_STATES-1:0]  cur_set;
	logic [NUM_STATES-1:0]  nxt_set;
	logic [SYMBOL_BITS-1:0] wr_addr;
	logic                   sym_in_range;

	// A symbol is in range when no bit above the alphabet width is set.
	assign sym_in_range = ((symbol >> SYMBOL_BITS) == '0);

	// Item capture on the input beat.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q    <= req_type;
			from_q   <= from_state;
			sym_q    <= symbol[SYMBOL_BITS-1:0];
			sym_ok_q <= sym_in_range;
			mask_q   <= next_mask[TW-1:0];
			last_q   <= is_last;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			accept_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_START_STATE: start_q  <= cfg_wdata[STATE_W-1:0];
				REG_ACCEPT_MASK: accept_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The clearing pass writes all banks at the counter address; updates use the item symbol.
	assign wr_addr = cmd.clear_en ? clr_cnt_q : sym_q;

	// One memory per source state, all read at the same symbol address.
	for (genvar b = 0; b < NUM_STATES; b++) begin : g_bank
		logic [TW-1:0] mem [DEPTH];
		logic          we;
		logic [TW-1:0] wdata;

		assign we    = cmd.clear_en || (cmd.tbl_wr && sym_ok_q && (int'(from_q) == b));
		assign wdata = cmd.clear_en ? '0 : (rd_q[b] | mask_q);

		always_ff @(posedge clk) begin
			if (we) begin
				mem[wr_addr] <= wdata;
			end
			if (cmd.capture) begin
				rd_q[b] <= mem[symbol[SYMBOL_BITS-1:0]];
			end
		end
	end

	// Start set and accept mask at the width of the state vector.
	always_comb begin
		for (int i = 0; i < NUM_STATES; i++) begin
			start_set[i] = (int'(start_q) == i);
		end
		accept_ns         = '0;
		accept_ns[TW-1:0] = accept_q[TW-1:0];
	end

	// Union of the entries of all active states for the captured symbol.
	always_comb begin
		cur_set = fresh_q ? start_set : active_q;
		nxt_set = '0;
		if (sym_ok_q) begin
			for (int s = 0; s < NUM_STATES; s++) begin
				if (cur_set[s]) nxt_set[TW-1:0] = nxt_set[TW-1:0] | rd_q[s];
			end
		end
	end

	// Active set, string start flag and the clearing counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			fresh_q   <= 1'b1;
			clr_cnt_q <= '0;
		end else begin
			if (cmd.step) begin
				active_q <= nxt_set;
				fresh_q  <= 1'b0;
			end else if (cmd.report) begin
				active_q <= '0;
				fresh_q  <= 1'b1;
			end
			if (cmd.clear_en) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	// Result register; an empty string starts from the start set and never dies.
	always_ff @(posedge clk) begin
		if (cmd.report) begin
			matched_q <= |((fresh_q ? start_set : active_q) & accept_ns);
			died_q    <= !fresh_q && (active_q == '0);
		end
	end

	assign matched = matched_q;
	assign died    = died_q;

	assign status.clear_done = (clr_cnt_q == '1);
	assign status.req_type   = req_q;
	assign status.is_last    = last_q;

endmodule
`default_nettype wire

@@ sv/nfa_state_set_matcher_top.sv @@
// Top level of the automaton matcher: controller and datapath.
//
// Simulates a nondeterministic automaton as a set of active states. The
// transition table is held in one memory bank per source state, each
// 2**SYMBOL_BITS entries deep, so all entries for one symbol are read in a
// single registered access. A table write and a string symbol each take a
// registered bank read, then a read-modify-write or set update; the last
// symbol of a string then goes on to the report state and an end marker goes
// straight to it, the result then waiting only for the output register to be
// free. An unused request code is taken and ignored. After reset the block runs
// a clearing pass over all 2**SYMBOL_BITS addresses of the banks and
// takes no input beat meanwhile; configuration writes are taken at any time.
`default_nettype none
module nfa_state_set_matcher_top #(
	parameter int NUM_STATES  = 32,
	parameter int SYMBOL_BITS = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [nfa_ssm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [nfa_ssm_pkg::MASK_W-1:0]    cfg_wdata,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [nfa_ssm_pkg::REQ_W-1:0]     req_type,
	input  wire logic [nfa_ssm_pkg::STATE_W-1:0]   from_state,
	input  wire logic [nfa_ssm_pkg::SYM_W-1:0]     symbol,
	input  wire logic [nfa_ssm_pkg::MASK_W-1:0]    next_mask,
	input  wire logic                              is_last,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   matched,
	output logic                                   died
);
	import nfa_ssm_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Sequencing of each beat.
	nfa_ssm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	// Table banks, active set and result register.
	nfa_ssm_dp #(
		.NUM_STATES  (NUM_STATES),
		.SYMBOL_BITS (SYMBOL_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.req_type   (req_type),
		.from_state (from_state),
		.symbol     (symbol),
		.next_mask  (next_mask),
		.is_last    (is_last),
		.matched    (matched),
		.died       (died)
	);

endmodule
`default_nettype wire

@@ sv/nfa_ssm_checker.sv @@
// Port-level checker of the automaton matcher and its bind.
`default_nettype none
`include "assert_macros.svh"
module nfa_ssm_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic [nfa_ssm_pkg::REQ_W-1:0] req_type,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic                          matched,
	input wire logic                          died
);
	import nfa_ssm_pkg::*;

	// A stalled result beat holds its payload.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(matched) && $stable(died), "stalled result beat changed")

	// An empty set cannot hold an accepting state.
	`ASSERT_CLK(a_died_no_match, clk, arst_n, !(out_valid && died && matched), "result both died and matched")

	// A new result follows a cycle in which the block was busy with an item.
	`ASSERT_CLK(a_result_after_work, clk, arst_n, $rose(out_valid) |-> $past(!in_ready), "result appeared while idle")

	// Table writes and symbols hold off the next beat while the table access runs.
	`ASSERT_NEXT(a_two_cycle_item, clk, arst_n, in_valid && in_ready && (req_type == REQ_WRITE || req_type == REQ_SYMBOL), !in_ready, "next beat taken during table access")

endmodule

bind nfa_state_set_matcher_top nfa_ssm_checker u_nfa_ssm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.req_type  (req_type),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.matched   (matched),
	.died      (died)
);
`default_nettype wire
